>>> design/rrd_pkg.sv
package rrd_pkg;

    localparam int unsigned MAX_REGION_BYTES_DEF = 32'd16777216;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] ENC_RAW = 8'd0;
    localparam logic [7:0] ENC_RLE = 8'd1;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned EXP_W      = 25;
    localparam int unsigned OFFSET_W   = 24;
    localparam int unsigned COUNT_W    = 16;

    // register indexes on the configuration port
    localparam logic CFG_EXPECTED_SIZE = 1'b0;
    localparam logic CFG_BYTE_BUDGET   = 1'b1;

    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_SIZE        = 3'd1;
    localparam logic [2:0] ERR_HDR_BUDGET  = 3'd2;
    localparam logic [2:0] ERR_RAW_BUDGET  = 3'd3;
    localparam logic [2:0] ERR_TRIP_BUDGET = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

    // one input beat as it travels from the queue to the decoder
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_queue_head;

endpackage

>>> design/rrd_front.sv
module rrd_front
    import rrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_beat            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;
    t_beat            in_beat;

    assign in_beat.data_byte = s_axis_tdata;
    assign in_beat.first     = s_axis_tuser;

    assign s_axis_tready = (r_count != FULL_CNT);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_head.valid  = (r_count != '0);
    assign o_head.beat   = r_mem[r_rptr];
    assign pop           = i_pop && o_head.valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_beat;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0) || !pop)
        else $error("queue popped while empty");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FULL_CNT) |-> !s_axis_tready)
        else $error("queue ready while full");
`endif

endmodule

>>> design/rrd_back.sv
module rrd_back
    import rrd_pkg::*;
#(
    parameter logic [31:0] MAX_REGION_BYTES = MAX_REGION_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_queue_head           i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OFFSET_W-1:0]   o_offset,
    output logic [7:0]            o_value,
    output logic [COUNT_W-1:0]    o_count,
    output logic                  o_last,
    output logic [2:0]            o_err
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_RAW,
        PH_RLE,
        PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [2:0]          r_hpos, n_hpos;
    logic [31:0]         r_dsize, n_dsize;
    logic [7:0]          r_enc, n_enc;
    logic [31:0]         r_consumed, n_consumed;
    logic [EXP_W-1:0]    r_produced, n_produced;
    logic [1:0]          r_tpos, n_tpos;
    logic [COUNT_W-1:0]  r_run, n_run;
    logic [EXP_W-1:0]    r_exp;
    logic [31:0]         r_budget;

    logic                r_out_valid;
    logic [OFFSET_W-1:0] r_out_offset;
    logic [7:0]          r_out_value;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_last;
    logic [2:0]          r_out_err;

    logic                take;
    logic                live;
    logic [7:0]          b;
    logic                res_valid;
    logic [OFFSET_W-1:0] res_offset;
    logic [7:0]          res_value;
    logic [COUNT_W-1:0]  res_count;
    logic                res_last;
    logic [2:0]          res_err;
    logic                trip_over;
    logic [EXP_W:0]      rem;

    assign take = i_head.valid && (!r_out_valid || i_ready);
    assign b    = i_head.beat.data_byte;

    always_comb begin
        n_phase    = r_phase;
        n_hpos     = r_hpos;
        n_dsize    = r_dsize;
        n_enc      = r_enc;
        n_consumed = r_consumed;
        n_produced = r_produced;
        n_tpos     = r_tpos;
        n_run      = r_run;
        live       = 1'b0;
        res_valid  = 1'b0;
        res_offset = r_produced[OFFSET_W-1:0];
        res_value  = '0;
        res_count  = '0;
        res_last   = 1'b0;
        res_err    = ERR_OK;
        trip_over  = 1'b0;
        rem        = '0;

        if (take) begin
            live = 1'b1;
            if (i_head.beat.first) begin
                n_phase    = PH_HEADER;
                n_hpos     = '0;
                n_dsize    = '0;
                n_enc      = '0;
                n_consumed = '0;
                n_produced = '0;
                n_tpos     = '0;
                n_run      = '0;
            end else if (r_phase != PH_HEADER && r_phase != PH_RAW && r_phase != PH_RLE) begin
                live = 1'b0;
            end
        end

        if (live) begin
            n_consumed = n_consumed + 32'd1;
            // next triplet would end past the budget
            trip_over  = ({1'b0, n_consumed} + 33'd3) > {1'b0, r_budget};
            res_offset = n_produced[OFFSET_W-1:0];
            rem        = {1'b0, r_exp} - {1'b0, n_produced};

            case (n_phase)
                PH_HEADER: begin
                    if (n_hpos == 3'd0 && r_budget < 32'd8) begin
                        n_phase   = PH_DONE;
                        res_valid = 1'b1;
                        res_last  = 1'b1;
                        res_err   = ERR_HDR_BUDGET;
                    end else begin
                        case (n_hpos)
                            3'd0:    n_dsize[7:0]   = b;
                            3'd1:    n_dsize[15:8]  = b;
                            3'd2:    n_dsize[23:16] = b;
                            3'd3:    n_dsize[31:24] = b;
                            3'd4:    n_enc          = b;
                            default: n_enc          = n_enc;
                        endcase
                        if (n_hpos == 3'd7) begin
                            res_last = 1'b1;
                            if (n_dsize != {7'b0, r_exp} ||
                                    {7'b0, r_exp} > MAX_REGION_BYTES) begin
                                res_valid = 1'b1;
                                res_err   = ERR_SIZE;
                            end else if (n_enc == ENC_RAW) begin
                                if ((33'd8 + {8'b0, r_exp}) > {1'b0, r_budget}) begin
                                    res_valid = 1'b1;
                                    res_err   = ERR_RAW_BUDGET;
                                end else if (r_exp == '0) begin
                                    res_valid = 1'b1;
                                end
                            end else if (n_enc == ENC_RLE) begin
                                if (r_exp == '0) begin
                                    res_valid = 1'b1;
                                end else if (trip_over) begin
                                    res_valid = 1'b1;
                                    res_err   = ERR_TRIP_BUDGET;
                                end
                            end else begin
                                res_valid = 1'b1;
                                res_err   = ERR_OVERFLOW;
                            end
                            if (res_valid) begin
                                n_phase = PH_DONE;
                            end else if (n_enc == ENC_RAW) begin
                                n_phase = PH_RAW;
                            end else begin
                                n_phase = PH_RLE;
                                n_tpos  = '0;
                            end
                        end else begin
                            n_hpos = n_hpos + 3'd1;
                        end
                    end
                end
                PH_RAW: begin
                    res_valid  = 1'b1;
                    res_value  = b;
                    res_count  = COUNT_W'(1);
                    n_produced = n_produced + 1'b1;
                    if (({1'b0, r_produced} + 1'b1) >= {1'b0, r_exp}) begin
                        n_phase  = PH_DONE;
                        res_last = 1'b1;
                    end
                end
                PH_RLE: begin
                    case (n_tpos)
                        2'd0: begin
                            n_run  = {8'b0, b};
                            n_tpos = 2'd1;
                        end
                        2'd1: begin
                            n_run[15:8] = b;
                            n_tpos      = 2'd2;
                        end
                        default: begin
                            n_tpos = 2'd0;
                            // sign bit of rem: produced already beyond region
                            if (rem[EXP_W] || {{(EXP_W-COUNT_W){1'b0}}, n_run} > rem[EXP_W-1:0])
                            begin
                                n_phase   = PH_DONE;
                                res_valid = 1'b1;
                                res_last  = 1'b1;
                                res_err   = ERR_OVERFLOW;
                            end else begin
                                n_produced = n_produced + EXP_W'(n_run);
                                res_value  = (n_run == '0) ? 8'd0 : b;
                                res_count  = n_run;
                                if ({{(EXP_W-COUNT_W){1'b0}}, n_run} == rem[EXP_W-1:0]) begin
                                    n_phase   = PH_DONE;
                                    res_valid = 1'b1;
                                    res_last  = 1'b1;
                                end else if (trip_over) begin
                                    n_phase   = PH_DONE;
                                    res_valid = 1'b1;
                                    res_last  = 1'b1;
                                    res_err   = ERR_TRIP_BUDGET;
                                end else begin
                                    res_valid = (n_run != '0);
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = n_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hpos      <= '0;
            r_dsize     <= '0;
            r_enc       <= '0;
            r_consumed  <= '0;
            r_produced  <= '0;
            r_tpos      <= '0;
            r_run       <= '0;
            r_exp       <= '0;
            r_budget    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hpos     <= n_hpos;
            r_dsize    <= n_dsize;
            r_enc      <= n_enc;
            r_consumed <= n_consumed;
            r_produced <= n_produced;
            r_tpos     <= n_tpos;
            r_run      <= n_run;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPECTED_SIZE: r_exp    <= i_cfg_data[EXP_W-1:0];
                    CFG_BYTE_BUDGET:   r_budget <= i_cfg_data;
                    default:           r_budget <= r_budget;
                endcase
            end
            if (take) begin
                r_out_valid <= res_valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_offset <= res_offset;
            r_out_value  <= res_value;
            r_out_count  <= res_count;
            r_out_last   <= res_last;
            r_out_err    <= res_err;
        end
    end

    assign o_pop    = take;
    assign o_valid  = r_out_valid;
    assign o_offset = r_out_offset;
    assign o_value  = r_out_value;
    assign o_count  = r_out_count;
    assign o_last   = r_out_last;
    assign o_err    = r_out_err;

`ifndef ASSERT_OFF
    a_last_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_phase == PH_DONE)
        else $error("final beat pending but decoder not finished");
    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_err != ERR_OK) |-> r_out_last)
        else $error("error reported on a non-final beat");
    a_tpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos != 2'd3)
        else $error("triplet position out of range");
`endif

endmodule

>>> design/region_rle_or_raw_decoder.sv
// Decodes a stored memory region, one byte per input beat, into fill commands.
// Each region starts with a beat flagged in tuser; the 8-byte header carries the
// little-endian decoded size and the encoding (raw or run-length triplets of a
// 16-bit count and a value). A byte per clock is sustained while the result side
// keeps up; a result passes through a queue slot, then the output register.
// A four-beat queue separates the input from the decoder, which
// handles one beat per cycle whenever the output register is free or being taken.
// The final result of a region has tlast set and the status code in tuser; bytes
// outside a live region give no result. Configuration may be written while idle.
module region_rle_or_raw_decoder
    import rrd_pkg::*;
#(
    parameter logic [31:0] MAX_REGION_BYTES = MAX_REGION_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic                  s_axis_tuser,   // first
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // write_offset, fill_value, fill_count
    output logic                  m_axis_tlast,   // done_res
    output logic [2:0]            m_axis_tuser    // error_code
);

    t_queue_head         head;
    logic                pop;
    logic [OFFSET_W-1:0] out_offset;
    logic [7:0]          out_value;
    logic [COUNT_W-1:0]  out_count;

    rrd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (head),
        .i_pop         (pop)
    );

    rrd_back #(
        .MAX_REGION_BYTES (MAX_REGION_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_offset    (out_offset),
        .o_value     (out_value),
        .o_count     (out_count),
        .o_last      (m_axis_tlast),
        .o_err       (m_axis_tuser)
    );

    assign m_axis_tdata = {out_count, out_value, out_offset};

endmodule

>>> tb/region_fill_checker.sv
`timescale 1ns / 1ps

module region_fill_checker
    import rrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_data,   // data_byte
    input  logic                  i_in_first,  // first
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [47:0]           i_out_data,  // write_offset, fill_value, fill_count
    input  logic                  i_out_last,  // done_res
    input  logic [2:0]            i_out_user,  // error_code
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_checked,
    output int                    o_closed
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_RAW,
        PH_RLE,
        PH_DONE
    } t_region_phase;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          value;
        logic [COUNT_W-1:0]  count;
        logic                done;
        logic [2:0]          err;
    } t_fill;

    // configuration copy
    logic [EXP_W-1:0]  exp_size;
    logic [31:0]       budget;

    // decoder state copy
    t_region_phase     region_phase;
    logic [2:0]        hdr_pos;
    logic [31:0]       size_seen;
    logic [7:0]        enc_seen;
    logic [31:0]       consumed;
    logic [EXP_W-1:0]  produced;
    logic [1:0]        trip_pos;
    logic [15:0]       run_len;

    t_fill             expected_fills[$];
    int                mismatch_count;
    int                checked_count;
    int                closed_count;

    function automatic t_fill make_fill(input logic [EXP_W-1:0] off, input logic [7:0] val,
                                        input logic [15:0] cnt, input logic done,
                                        input logic [2:0] err);
        t_fill f;
        f.offset = off[OFFSET_W-1:0];
        f.value  = val;
        f.count  = cnt;
        f.done   = done;
        f.err    = err;
        return f;
    endfunction

    // status-only beat that ends the region
    function automatic t_fill close_region(input logic [2:0] err);
        region_phase = PH_DONE;
        return make_fill(produced, 8'd0, 16'd0, 1'b1, err);
    endfunction

    function automatic bit triplet_short();
        return ({1'b0, consumed} + 33'd3) > {1'b0, budget};
    endfunction

    function automatic bit decode_beat(input logic [7:0] b, input logic f, output t_fill r);
        logic [EXP_W-1:0] left_bytes;
        logic [EXP_W-1:0] off;
        logic [EXP_W-1:0] run;
        r = '0;
        if (f) begin
            region_phase = PH_HEADER;
            hdr_pos      = 3'd0;
            size_seen    = 32'd0;
            enc_seen     = 8'd0;
            consumed     = 32'd0;
            produced     = '0;
            trip_pos     = 2'd0;
            run_len      = 16'd0;
        end else if (region_phase != PH_HEADER && region_phase != PH_RAW &&
                     region_phase != PH_RLE) begin
            return 1'b0;
        end
        consumed = consumed + 32'd1;

        case (region_phase)
            PH_HEADER: begin
                if (hdr_pos == 3'd0 && budget < 32'd8) begin
                    r = close_region(ERR_HDR_BUDGET);
                    return 1'b1;
                end
                if (hdr_pos < 3'd4)
                    size_seen[8*hdr_pos +: 8] = b;
                else if (hdr_pos == 3'd4)
                    enc_seen = b;
                if (hdr_pos != 3'd7) begin
                    hdr_pos = hdr_pos + 3'd1;
                    return 1'b0;
                end
                // size check wins over the encoding check
                if (size_seen != {7'd0, exp_size} || {7'd0, exp_size} > MAX_REGION_BYTES_DEF) begin
                    r = close_region(ERR_SIZE);
                    return 1'b1;
                end
                if (enc_seen == ENC_RAW) begin
                    if (33'd8 + {8'd0, exp_size} > {1'b0, budget}) begin
                        r = close_region(ERR_RAW_BUDGET);
                        return 1'b1;
                    end
                    if (exp_size == '0) begin
                        r = close_region(ERR_OK);
                        return 1'b1;
                    end
                    region_phase = PH_RAW;
                    return 1'b0;
                end
                if (enc_seen == ENC_RLE) begin
                    if (exp_size == '0) begin
                        r = close_region(ERR_OK);
                        return 1'b1;
                    end
                    if (triplet_short()) begin
                        r = close_region(ERR_TRIP_BUDGET);
                        return 1'b1;
                    end
                    region_phase = PH_RLE;
                    trip_pos     = 2'd0;
                    return 1'b0;
                end
                r = close_region(ERR_OVERFLOW);
                return 1'b1;
            end
            PH_RAW: begin
                off      = produced;
                produced = produced + 1'b1;
                if (produced >= exp_size) begin
                    region_phase = PH_DONE;
                    r = make_fill(off, b, 16'd1, 1'b1, ERR_OK);
                end else begin
                    r = make_fill(off, b, 16'd1, 1'b0, ERR_OK);
                end
                return 1'b1;
            end
            PH_RLE: begin
                if (trip_pos == 2'd0) begin
                    run_len  = {8'd0, b};
                    trip_pos = 2'd1;
                    return 1'b0;
                end
                if (trip_pos == 2'd1) begin
                    run_len[15:8] = b;
                    trip_pos      = 2'd2;
                    return 1'b0;
                end
                trip_pos   = 2'd0;
                run        = {9'd0, run_len};
                off        = produced;
                left_bytes = exp_size - produced;
                if (produced > exp_size || run > left_bytes) begin
                    r = close_region(ERR_OVERFLOW);
                    return 1'b1;
                end
                produced = produced + run;
                if (produced == exp_size) begin
                    region_phase = PH_DONE;
                    if (run_len == 16'd0)
                        r = make_fill(off, 8'd0, 16'd0, 1'b1, ERR_OK);
                    else
                        r = make_fill(off, b, run_len, 1'b1, ERR_OK);
                    return 1'b1;
                end
                // next triplet would not fit: the run just decoded carries the error
                if (triplet_short()) begin
                    region_phase = PH_DONE;
                    if (run_len == 16'd0)
                        r = make_fill(off, 8'd0, 16'd0, 1'b1, ERR_TRIP_BUDGET);
                    else
                        r = make_fill(off, b, run_len, 1'b1, ERR_TRIP_BUDGET);
                    return 1'b1;
                end
                if (run_len == 16'd0)
                    return 1'b0;
                r = make_fill(off, b, run_len, 1'b0, ERR_OK);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_fill got;
        t_fill want;
        t_fill predicted;
        if (!i_rst_n) begin
            exp_size       = '0;
            budget         = 32'd0;
            region_phase   = PH_IDLE;
            hdr_pos        = 3'd0;
            size_seen      = 32'd0;
            enc_seen       = 8'd0;
            consumed       = 32'd0;
            produced       = '0;
            trip_pos       = 2'd0;
            run_len        = 16'd0;
            mismatch_count = 0;
            checked_count  = 0;
            closed_count   = 0;
            expected_fills.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_EXPECTED_SIZE)
                    exp_size = i_cfg_data[EXP_W-1:0];
                else if (i_cfg_index == CFG_BYTE_BUDGET)
                    budget = i_cfg_data;
            end

            // compare before predicting, so a beat can never meet its own result
            if (i_out_valid && i_out_ready) begin
                got.offset = i_out_data[OFFSET_W-1:0];
                got.value  = i_out_data[OFFSET_W +: 8];
                got.count  = i_out_data[OFFSET_W+8 +: COUNT_W];
                got.done   = i_out_last;
                got.err    = i_out_user;
                if (expected_fills.size() == 0) begin
                    report_mismatch("unexpected result beat", i_out_data[31:0], 32'd0);
                end else begin
                    want = expected_fills.pop_front();
                    checked_count++;
                    if (want.done)
                        closed_count++;
                    if (got.offset != want.offset)
                        report_mismatch("write_offset", got.offset, want.offset);
                    if (got.value != want.value)
                        report_mismatch("fill_value", got.value, want.value);
                    if (got.count != want.count)
                        report_mismatch("fill_count", got.count, want.count);
                    if (got.done != want.done)
                        report_mismatch("done_res", got.done, want.done);
                    if (got.err != want.err)
                        report_mismatch("error_code", got.err, want.err);
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (decode_beat(i_in_data, i_in_first, predicted))
                    expected_fills.push_back(predicted);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_fills.size();
        o_checked     <= checked_count;
        o_closed      <= closed_count;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rrd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_BEATS = 1900;
    localparam int QUIET_BEATS  = 1600;   // no idling on either side past this
    localparam int BIG_PHASE    = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // data_byte
    logic                  s_axis_tuser;   // first
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // write_offset, fill_value, fill_count
    logic                  m_axis_tlast;   // done_res
    logic [2:0]            m_axis_tuser;   // error_code

    int mismatches;
    int outstanding;
    int checked;
    int closed;

    int          beats_sent;
    int          regions_sent;
    int          configs_used;
    bit          src_idle_on;
    bit          snk_idle_on;
    logic [31:0] cur_exp;
    logic [31:0] cur_budget;

    region_rle_or_raw_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    region_fill_checker fill_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_first    (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .i_out_user    (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_closed      (closed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles, %0d results still due", CYCLE_LIMIT, outstanding);
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (snk_idle_on && beats_sent < QUIET_BEATS && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic f);
        if (src_idle_on && beats_sent < QUIET_BEATS && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // drop valid, let all results drain, then let ignored beats clear the queue
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] exp_val, input logic [31:0] budget_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EXPECTED_SIZE;
        i_cfg_data  <= exp_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_BYTE_BUDGET;
        i_cfg_data  <= budget_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_exp    = exp_val;
        cur_budget = budget_val;
        configs_used++;
    endtask

    task automatic send_header(input logic [31:0] size_field, input logic [7:0] enc);
        send_beat(size_field[7:0], 1'b1);
        send_beat(size_field[15:8], 1'b0);
        send_beat(size_field[23:16], 1'b0);
        send_beat(size_field[31:24], 1'b0);
        send_beat(enc, 1'b0);
        repeat (3) send_beat(8'($urandom), 1'b0);
    endtask

    // mode 0: random region kind, 1: run-length with a matching header, 2: raw with a matching header
    task automatic send_region(input int mode);
        logic [7:0]  bytes_q[$];
        logic [31:0] size_field;
        logic [7:0]  enc;
        int          kind;
        int          left_bytes;
        int          cnt;
        int          r;
        int          n;
        kind = (mode == 1) ? 0 : (mode == 2) ? 60 : $urandom_range(0, 99);
        regions_sent++;
        if (kind >= 92) begin
            // stray bytes with no region start
            repeat ($urandom_range(1, 6)) send_beat(8'($urandom), 1'b0);
            return;
        end
        size_field = cur_exp;
        enc = (kind < 50) ? ENC_RLE : ENC_RAW;
        if (kind >= 78 && kind < 86) begin
            size_field = cur_exp ^ (32'd1 << $urandom_range(0, 31));
            enc = $urandom_range(0, 1) ? ENC_RLE : ENC_RAW;
        end else if (kind >= 86) begin
            enc = 8'($urandom_range(2, 255));
        end
        bytes_q.push_back(size_field[7:0]);
        bytes_q.push_back(size_field[15:8]);
        bytes_q.push_back(size_field[23:16]);
        bytes_q.push_back(size_field[31:24]);
        bytes_q.push_back(enc);
        repeat (3) bytes_q.push_back(8'($urandom));

        if (enc == ENC_RLE) begin
            left_bytes = cur_exp;
            while (left_bytes > 0) begin
                r = $urandom_range(0, 15);
                if (left_bytes > 65535)
                    cnt = 65535;
                else if (r == 0)
                    cnt = 0;
                else if (r == 1)
                    cnt = left_bytes + 1;          // overflows the region
                else if (r == 2)
                    cnt = left_bytes;
                else
                    cnt = $urandom_range(1, (left_bytes < 9) ? left_bytes : 9);
                bytes_q.push_back(cnt[7:0]);
                bytes_q.push_back(cnt[15:8]);
                bytes_q.push_back(8'($urandom));
                if (cnt > left_bytes)
                    break;
                left_bytes -= cnt;
            end
        end else if (enc == ENC_RAW) begin
            n = (cur_exp > 300) ? $urandom_range(0, 16) : cur_exp;
            repeat (n) bytes_q.push_back(8'($urandom));
        end

        // broken region: cut short, the next start abandons it
        if (mode == 0 && bytes_q.size() > 1 && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, bytes_q.size() - 1);
            while (bytes_q.size() > n) void'(bytes_q.pop_back());
        end

        foreach (bytes_q[i])
            send_beat(bytes_q[i], i == 0);
    endtask

    initial begin
        logic [31:0] exp_val;
        logic [31:0] budget_val;
        int          phase_no;
        int          regions;
        int          r;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_EXPECTED_SIZE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 1'b0;
        src_idle_on   = 1'b0;
        snk_idle_on   = 1'b0;
        beats_sent    = 0;
        regions_sent  = 0;
        configs_used  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header past budget, a stray byte after the failure, then a restart
        set_config(32'd0, 32'd0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        wait_idle();

        // empty raw region, size mismatch, unknown encoding
        set_config(32'd0, 32'hFFFF_FFFF);
        send_header(32'd0, ENC_RAW);
        send_header(32'hFFFF_FFFF, ENC_RAW);
        send_header(32'd0, 8'hFF);

        phase_no = 0;
        while (beats_sent < TARGET_BEATS) begin
            wait_idle();
            if (phase_no == BIG_PHASE) begin
                exp_val    = MAX_REGION_BYTES_DEF;
                budget_val = 32'hFFFF_FFFF;
            end else begin
                r = $urandom_range(0, 9);
                exp_val = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 :
                          (r == 9) ? $urandom_range(41, 300) : $urandom_range(2, 40);
                case ($urandom_range(0, 9))
                    0:       budget_val = $urandom_range(0, 7);
                    1:       budget_val = 32'hFFFF_FFFF;
                    2:       budget_val = exp_val + 32'd8;
                    3:       budget_val = exp_val + 32'd7;
                    4:       budget_val = 32'd8 + 3 * $urandom_range(0, 6) + $urandom_range(0, 2);
                    5:       budget_val = $urandom | 32'h8000_0000;
                    default: budget_val = exp_val + 32'd8 + $urandom_range(0, 64);
                endcase
            end
            set_config(exp_val, budget_val);

            if (phase_no == BIG_PHASE) begin
                send_region(2);
                send_region(1);
            end else begin
                regions = $urandom_range(3, 8);
                repeat (regions) begin
                    if (beats_sent >= QUIET_BEATS) begin
                        src_idle_on = 1'b0;
                        snk_idle_on = 1'b0;
                    end else begin
                        src_idle_on = ($urandom_range(0, 3) != 0);
                        snk_idle_on = ($urandom_range(0, 3) != 0);
                    end
                    send_region(0);
                end
            end
            phase_no++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d beats in %0d regions across %0d register settings",
                 beats_sent, regions_sent, configs_used);
        $display("Checked %0d fill results, %0d of them closing a region", checked, closed);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rrd_pkg.sv
design/rrd_front.sv
design/rrd_back.sv
design/region_rle_or_raw_decoder.sv
tb/region_fill_checker.sv
tb/tb.sv
